[sv/stack_queue_engine_top_defines.svh]
// Assertion macros shared by the stack/queue engine RTL.
`ifndef STACK_QUEUE_ENGINE_TOP_DEFINES_SVH
`define STACK_QUEUE_ENGINE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Implication or plain property, clocked on i_clk, off during reset.
`define SQE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// Condition that must never be seen at a clock edge.
`define SQE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define SQE_ASSERT(lbl, prop, msg)
`define SQE_NEVER(lbl, cond, msg)
`endif

`endif

[sv/sqe_pkg.sv]
// Types and codes of the stack/queue engine.
package sqe_pkg;

    localparam int DATA_W = 32;

    // Command codes carried in the request tuser
    typedef enum logic [2:0] {
        ACT_PUSH = 3'd0,
        ACT_POP  = 3'd1,
        ACT_PEEK = 3'd2,
        ACT_DUMP = 3'd3,
        ACT_SWAP = 3'd4
    } t_action;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_SHORT = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CO_HOLD     = 3'd0,
        CO_PUSH_TOP = 3'd1,
        CO_POP      = 3'd2,
        CO_SWAP     = 3'd3,
        CO_APPEND   = 3'd4,
        CO_ROTATE   = 3'd5
    } t_cell_op;

    typedef struct packed {
        t_cell_op            op;
        logic [DATA_W-1:0]   value;
    } t_cell_ctl;

endpackage

[sv/sqe_cell.sv]
// One storage cell of the chain: holds one entry, takes from a neighbor, the top cell or the command value.
module sqe_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                        i_clk,
    input  sqe_pkg::t_cell_ctl          i_ctl,
    input  logic [CW-1:0]               i_count,
    input  logic [sqe_pkg::DATA_W-1:0]  i_above,
    input  logic [sqe_pkg::DATA_W-1:0]  i_below,
    input  logic [sqe_pkg::DATA_W-1:0]  i_top,
    output logic [sqe_pkg::DATA_W-1:0]  o_data
);
    import sqe_pkg::*;

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // Source select from this cell's position and the entry count
    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CO_PUSH_TOP: n_data = i_above;
            CO_POP:      n_data = i_below;
            CO_SWAP: begin
                if (IDX == 0) begin
                    n_data = i_below;
                end else if (IDX == 1) begin
                    n_data = i_above;
                end
            end
            CO_APPEND: begin
                if (i_count == CW'(IDX)) begin
                    n_data = i_ctl.value;
                end
            end
            CO_ROTATE: begin
                // top entry wraps to the bottom, the rest move up
                if (CW'(IDX + 1) == i_count) begin
                    n_data = i_top;
                end else if (CW'(IDX + 1) < i_count) begin
                    n_data = i_below;
                end
            end
            default: n_data = r_data;
        endcase
    end

    // Entry payload, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[sv/stack_queue_engine_top.sv]
// Stack/queue engine top: command control, output register and cell chain.
// A result is registered in the output register when its request is accepted; a dump first enters the dump state.
// Push, pop, peek and swap can be accepted back to back while the output register is free.
// A dump of N entries emits N results, the chain rotating one cell per result; no request is taken until it ends.
// Reset (sync, active low) clears count, mode and output valid; entries are not cleared.
`include "stack_queue_engine_top_defines.svh"
module stack_queue_engine_top #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,      // [0] queue_mode
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [31:0] value
    input  logic [2:0]  s_axis_tuser,    // [2:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // [31:0] data
    output logic [1:0]  m_axis_tuser,    // [1:0] status
    output logic        m_axis_tlast
);
    import sqe_pkg::*;

    localparam int          CW      = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    t_state            r_state,   n_state;
    logic [CW-1:0]     r_count,   n_count;
    logic [CW-1:0]     r_left,    n_left;
    logic              r_mode,    n_mode;
    logic              r_m_valid, n_m_valid;
    logic [DATA_W-1:0] r_m_data,  n_m_data;
    t_status           r_m_status, n_m_status;
    logic              r_m_last,  n_m_last;

    t_cell_ctl         w_ctl;
    logic [DATA_W-1:0] w_cell [DEPTH];
    logic [DATA_W-1:0] w_top;
    logic              w_out_free;
    logic              w_s_acc;

    assign w_top         = w_cell[0];
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // Command decode and next-state logic
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_left     = r_left;
        n_mode     = r_mode;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_m_status = r_m_status;
        n_m_last   = r_m_last;
        w_ctl.op    = CO_HOLD;
        w_ctl.value = s_axis_tdata;

        if (i_cfg_valid) begin
            n_mode = i_cfg_data;
        end
        if (w_out_free) begin
            n_m_valid = 1'b0;
        end

        if (w_s_acc) begin
            n_m_valid  = 1'b1;
            n_m_status = ST_OK;
            n_m_data   = '0;
            n_m_last   = 1'b1;
            case (s_axis_tuser)
                ACT_PUSH: begin
                    if (r_count == DEPTH_C) begin
                        n_m_status = ST_FULL;
                    end else begin
                        w_ctl.op = (r_mode && r_count != '0) ? CO_APPEND : CO_PUSH_TOP;
                        n_count  = r_count + 1'b1;
                    end
                end
                ACT_POP: begin
                    if (r_count == '0) begin
                        n_m_status = ST_EMPTY;
                    end else begin
                        w_ctl.op = CO_POP;
                        n_count  = r_count - 1'b1;
                    end
                end
                ACT_PEEK: begin
                    if (r_count == '0) begin
                        n_m_status = ST_EMPTY;
                    end else begin
                        n_m_data = w_top;
                    end
                end
                ACT_DUMP: begin
                    if (r_count == '0) begin
                        n_m_status = ST_EMPTY;
                    end else begin
                        // results come from the dump walk
                        n_m_valid = 1'b0;
                        n_state   = S_DUMP;
                        n_left    = r_count;
                    end
                end
                ACT_SWAP: begin
                    if (r_count < CW'(2)) begin
                        n_m_status = ST_SHORT;
                    end else begin
                        w_ctl.op = CO_SWAP;
                    end
                end
                default: ;
            endcase
        end else if (r_state == S_DUMP && w_out_free) begin
            // emit top, rotate the filled cells up by one
            n_m_valid  = 1'b1;
            n_m_status = ST_OK;
            n_m_data   = w_top;
            n_m_last   = (r_left == CW'(1));
            w_ctl.op   = CO_ROTATE;
            n_left     = r_left - 1'b1;
            if (r_left == CW'(1)) begin
                n_state = S_IDLE;
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_left    <= '0;
            r_mode    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_left    <= n_left;
            r_mode    <= n_mode;
            r_m_valid <= n_m_valid;
        end
        r_m_data   <= n_m_data;
        r_m_status <= n_m_status;
        r_m_last   <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tlast  = r_m_last;

    // Cell chain, cell 0 holds the top entry
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic [DATA_W-1:0] w_above;
        logic [DATA_W-1:0] w_below;
        if (gi == 0) begin : g_first
            assign w_above = w_ctl.value;
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_last
            assign w_below = w_cell[gi];
        end else begin : g_inner
            assign w_below = w_cell[gi+1];
        end
        sqe_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_above (w_above),
            .i_below (w_below),
            .i_top   (w_top),
            .o_data  (w_cell[gi])
        );
    end

    // Checks
    `SQE_NEVER(a_count_bound, r_count > DEPTH_C, "entry count above depth")
    `SQE_NEVER(a_dump_left, (r_state == S_DUMP) && (r_left == '0 || r_left > r_count),
        "dump counter out of range")
    `SQE_ASSERT(a_push_top,
        (w_s_acc && s_axis_tuser == ACT_PUSH && !r_mode && r_count != DEPTH_C)
        |=> (w_top == $past(s_axis_tdata)), "stack push did not land on top")
    `SQE_ASSERT(a_dump_end,
        (r_state == S_DUMP && w_out_free && r_left == CW'(1))
        |=> (r_m_valid && r_m_last && r_state == S_IDLE), "dump did not end with last")

endmodule
